>>> hdl/armt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package armt_pkg;

  // Address widths of a stored range.
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned END_W  = ADDR_W + 1;

  // Widths of the stream words.
  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 80;

  // Operation codes carried in the input tuser bit.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MERGE_WB,
    ST_SHIFT,
    ST_INS_HEAD,
    ST_RD_ISSUE,
    ST_FINISH
  } armt_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic set_ovf;
    logic merge_wb;
    logic shift;
    logic ins_head;
    logic rd_issue;
    logic finish;
  } armt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_op;
    logic inside_hit;
    logic scan_end;
    logic found;
    logic full;
    logic shift_end;
    logic out_free;
  } armt_status_t;

endpackage

`default_nettype wire

>>> hdl/armt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module armt_ctrl
  import armt_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire armt_status_t st,
  output armt_cmd_t         cmd
);

  armt_state_t state;
  armt_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = (st.in_op == OP_READ) ? ST_RD_ISSUE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (st.inside_hit) begin
          state_next = ST_FINISH;
        end else if (st.scan_end) begin
          if (st.found) begin
            state_next = ST_MERGE_WB;
          end else if (st.full) begin
            cmd.set_ovf = 1'b1;
            state_next  = ST_FINISH;
          end else begin
            state_next = ST_SHIFT;
          end
        end
      end
      ST_MERGE_WB: begin
        cmd.merge_wb = 1'b1;
        state_next   = ST_FINISH;
      end
      ST_SHIFT: begin
        cmd.shift = 1'b1;
        if (st.shift_end) begin
          state_next = ST_INS_HEAD;
        end
      end
      ST_INS_HEAD: begin
        cmd.ins_head = 1'b1;
        state_next   = ST_FINISH;
      end
      ST_RD_ISSUE: begin
        cmd.rd_issue = 1'b1;
        state_next   = ST_FINISH;
      end
      ST_FINISH: begin
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/armt_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module armt_datapath
  import armt_pkg::*;
#(
  parameter int unsigned MAX_RANGES = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  input  wire logic                  s_tuser,
  input  wire logic                  m_tready,
  output logic                       m_tvalid,
  output logic [OUT_DATA_W-1:0]      m_tdata,
  input  wire armt_cmd_t             cmd,
  output armt_status_t               st
);

  localparam int unsigned IW   = $clog2(MAX_RANGES);
  localparam int unsigned CW   = $clog2(MAX_RANGES + 1);
  localparam int unsigned CMPW = (CW > 4) ? CW : 4;

  // Range table storage.
  logic [ADDR_W-1:0] mem_s [MAX_RANGES];
  logic [END_W-1:0]  mem_t [MAX_RANGES];
  logic [ADDR_W-1:0] mem_s_q;
  logic [END_W-1:0]  mem_t_q;

  // Current item.
  logic              op;
  logic [ADDR_W-1:0] acc_addr;
  logic [END_W-1:0]  acc_end;
  logic [3:0]        idx;

  // Walk control.
  logic [CW-1:0] count;
  logic [CW-1:0] rd_ptr;
  logic [CW-1:0] w;
  logic [IW-1:0] f;
  logic [IW-1:0] shift_wa;
  logic          pend;
  logic          found;
  logic [ADDR_W-1:0] grow_s;
  logic [END_W-1:0]  grow_t;
  logic          covered;
  logic          ovf;
  logic          rd_valid;

  // Output register.
  logic [4:0]        o_total;
  logic              o_covered;
  logic              o_ovf;
  logic              o_valid;
  logic [ADDR_W-1:0] o_start;
  logic [END_W-1:0]  o_end;

  // Memory port signals.
  logic              we;
  logic [IW-1:0]     wa;
  logic [ADDR_W-1:0] wd_s;
  logic [END_W-1:0]  wd_t;
  logic              re;
  logic [IW-1:0]     ra;

  // Match tests against the original access.
  logic [END_W-1:0] a_x;
  logic [END_W-1:0] s_x;
  logic             contains;
  logic             low;
  logic             high;
  logic             match;
  logic             proc;
  logic             rd_hit;
  logic             out_free;

  assign a_x      = END_W'(acc_addr);
  assign s_x      = END_W'(mem_s_q);
  assign contains = (s_x <= a_x) && (mem_t_q >= acc_end);
  assign low      = (a_x <= s_x) && (acc_end >= s_x);
  assign high     = (a_x <= mem_t_q) && (acc_end > mem_t_q);
  assign match    = contains || low || high;
  assign proc     = cmd.scan && pend;
  assign rd_hit   = CMPW'(idx) < CMPW'(count);
  assign out_free = !m_tvalid || m_tready;

  // Status to the controller. The containment flag is only looked at while scanning.
  always_comb begin
    st.in_op      = s_tuser;
    st.inside_hit = pend && contains && !found;
    st.scan_end   = !pend && (rd_ptr == count);
    st.found      = found;
    st.full       = (count == CW'(MAX_RANGES));
    st.shift_end  = !pend && (rd_ptr == '0);
    st.out_free   = out_free;
  end

  // Memory address and write data selection.
  always_comb begin
    we   = 1'b0;
    wa   = '0;
    wd_s = mem_s_q;
    wd_t = mem_t_q;
    re   = 1'b0;
    ra   = '0;
    if (proc && !match) begin
      we = 1'b1;
      wa = IW'(w);
    end
    if (cmd.merge_wb) begin
      we   = 1'b1;
      wa   = f;
      wd_s = grow_s;
      wd_t = grow_t;
    end
    if (cmd.shift && pend) begin
      we = 1'b1;
      wa = shift_wa;
    end
    if (cmd.ins_head) begin
      we   = 1'b1;
      wa   = '0;
      wd_s = acc_addr;
      wd_t = acc_end;
    end
    if (cmd.scan) begin
      re = (rd_ptr != count);
      ra = IW'(rd_ptr);
    end
    if (cmd.shift) begin
      re = (rd_ptr != '0);
      ra = IW'(rd_ptr - 1'b1);
    end
    if (cmd.rd_issue) begin
      re = rd_hit;
      ra = IW'(idx);
    end
  end

  // Table memory with a registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_s[wa] <= wd_s;
      mem_t[wa] <= wd_t;
    end
    if (re) begin
      mem_s_q <= mem_s[ra];
      mem_t_q <= mem_t[ra];
    end
  end

  // Control registers of the walk.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      pend  <= 1'b0;
    end else begin
      pend <= re;
      if (cmd.merge_wb) begin
        count <= w;
      end else if (cmd.ins_head) begin
        count <= count + 1'b1;
      end
    end
  end

  // Per item working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op       <= s_tuser;
      acc_addr <= s_tdata[31:0];
      acc_end  <= END_W'(s_tdata[31:0]) + END_W'(s_tdata[47:32]);
      idx      <= s_tdata[51:48];
      rd_ptr   <= '0;
      w        <= '0;
      found    <= 1'b0;
      covered  <= 1'b0;
      ovf      <= 1'b0;
      rd_valid <= 1'b0;
    end else begin
      if (cmd.scan && re) begin
        rd_ptr <= rd_ptr + 1'b1;
      end else if (cmd.shift && re) begin
        rd_ptr   <= rd_ptr - 1'b1;
        shift_wa <= IW'(rd_ptr);
      end
      // Entries that stay move down to the write pointer.
      if (proc && (!match || !found)) begin
        w <= w + 1'b1;
      end
      // First matching entry grows to cover the access.
      if (proc && match && !found && !contains) begin
        found <= 1'b1;
        f     <= IW'(w);
        if (low) begin
          grow_s <= acc_addr;
          grow_t <= (acc_end > mem_t_q) ? acc_end : mem_t_q;
        end else begin
          grow_s <= mem_s_q;
          grow_t <= acc_end;
        end
      end
      // Later matching entries fold into the first one.
      if (proc && match && found) begin
        if (mem_s_q < grow_s) begin
          grow_s <= mem_s_q;
        end
        if (mem_t_q > grow_t) begin
          grow_t <= mem_t_q;
        end
      end
      if (proc && contains && !found) begin
        covered <= 1'b1;
      end
      if (cmd.set_ovf) begin
        ovf <= 1'b1;
      end
      if (cmd.rd_issue) begin
        rd_valid <= rd_hit;
      end
    end
  end

  // Result word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      o_total   <= 5'(count);
      o_covered <= covered;
      o_ovf     <= ovf;
      o_valid   <= rd_valid && (op == OP_READ);
      o_start   <= rd_valid ? mem_s_q : '0;
      o_end     <= rd_valid ? mem_t_q : '0;
    end
  end

  assign m_tdata = {7'b0, o_end, o_start, o_valid, o_ovf, o_covered, o_total};

  // The table never holds more than its depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_RANGES))
    else $error("range count exceeds table depth");

  // Compaction never writes ahead of the read pointer.
  a_wptr_behind: assert property (@(posedge clk) disable iff (rst)
    cmd.scan |-> (w <= rd_ptr))
    else $error("write pointer passed read pointer");

  // A merge write-back sets the count to the compacted length.
  a_merge_count: assert property (@(posedge clk) disable iff (rst)
    cmd.merge_wb |=> (count == $past(w)))
    else $error("count not updated after merge");

  // An insert result never claims both coverage and overflow, nor read data.
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(o_covered && o_ovf) && !(o_valid && (o_covered || o_ovf)))
    else $error("conflicting result flags");

endmodule

`default_nettype wire

>>> hdl/address_range_merge_tracker.sv
`timescale 1ns / 1ps
`default_nettype none
// An insert that adds a head entry scans the stored ranges, shifts them up by one, writes the
// head entry and loads the result. A merging insert scans, writes back the grown entry and loads
// the result; a covered or overflowing insert loads the result after the scan, and a read issues
// one table read and loads the result. Loading waits until the result register is free. One word
// is in work at a time; the next word is accepted only after the result is loaded.
// Reset (rst, synchronous) empties the table and drops any pending result; entries stay as is.

module address_range_merge_tracker
  import armt_pkg::*;
#(
  parameter int unsigned MAX_RANGES = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Input word.
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // access_addr[31:0], access_len[47:32], entry_index[51:48], zero fill to 56 bits.
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  // opcode[0].
  input  wire logic                  s_tuser,
  // Result word.
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // range_total[4:0], already_covered[5], table_overflow[6], entry_valid[7],
  // entry_start[39:8], entry_end[72:40], zero fill to 80 bits.
  output logic [OUT_DATA_W-1:0]      m_tdata
);

  armt_cmd_t    cmd;
  armt_status_t st;

  // Sequencer for the table walk.
  armt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  // Range table, compare logic and result register.
  armt_datapath #(
    .MAX_RANGES (MAX_RANGES)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .st       (st)
  );

endmodule

`default_nettype wire
